@@ hw/rtl/ordered_interval_table_assert.svh @@
// Assertion macros for the interval table RTL
`ifndef ORDERED_INTERVAL_TABLE_ASSERT_SVH
`define ORDERED_INTERVAL_TABLE_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define OIT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while in reset
`define OIT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/oit_pkg.sv @@
package oit_pkg;

  localparam int unsigned DEPTH = 16;
  // one spare slot holds the overflow entry of a dropped insert
  localparam int unsigned SLOTS = DEPTH + 1;
  localparam int unsigned CW    = $clog2(SLOTS + 1);

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_PURGE  = 1'b1
  } op_e;

  typedef struct packed {
    logic [7:0]  padding;
    logic        inline_flag;
    logic [15:0] image_id;
    logic [11:0] image_width;
    logic [11:0] image_height;
  } look_t;

  typedef struct packed {
    logic [15:0] start_pos;
    logic [15:0] end_pos;
    look_t       look;
    logic [31:0] bg_color;
    logic [1:0]  source;
    logic [31:0] stamp;
    logic        is_new;
  } entry_t;

  // per-cell shift control
  typedef struct packed {
    logic pop;
    logic load;
  } cell_ctl_t;

endpackage

@@ hw/rtl/oit_cell.sv @@
// One table slot: holds, takes its upper neighbor on a pop, or loads a push.
module oit_cell (
  input  logic               clk_i,
  input  oit_pkg::cell_ctl_t ctl_i,
  input  oit_pkg::entry_t    up_i,
  input  oit_pkg::entry_t    push_i,
  output oit_pkg::entry_t    ent_o
);

  oit_pkg::entry_t ent_q, ent_d;

  always_comb begin
    ent_d = ent_q;
    if (ctl_i.load) begin
      ent_d = push_i;
    end else if (ctl_i.pop) begin
      ent_d = up_i;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

  assign ent_o = ent_q;

endmodule

@@ hw/rtl/ordered_interval_table.sv @@
// Ordered interval table: up to DEPTH intervals kept in position order in a
// chain of slots that works as a queue. An operation streams every stored
// entry once out of the head slot and writes the survivors (and the new
// entry) back at the tail, one entry per cycle. An insert that does not
// replace an entry (placed in front of an entry or appended at the end)
// takes an extra step, and when a full table has to drop the insert a
// further pass takes the new entry back out; the result is then held
// until transferred. One item is in flight at a time.
`include "ordered_interval_table_assert.svh"

module ordered_interval_table (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        opcode_i,
  input  logic [15:0] start_pos_i,
  input  logic [15:0] end_pos_i,
  input  logic [7:0]  padding_i,
  input  logic        inline_flag_i,
  input  logic [15:0] image_id_i,
  input  logic [11:0] image_width_i,
  input  logic [11:0] image_height_i,
  input  logic [31:0] bg_color_i,
  input  logic [1:0]  source_i,
  input  logic [31:0] stamp_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        replaced_o,
  output logic        removed_any_o,
  output logic        dropped_o,
  output logic [4:0]  entries_o
);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_WALK  = 6'b000010,
    ST_TAIL  = 6'b000100,
    ST_CHECK = 6'b001000,
    ST_FIX   = 6'b010000,
    ST_DONE  = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic [oit_pkg::CW-1:0] cnt_q, cnt_d, rem_q, rem_d, wpos;
  logic placed_q, placed_d, repl_q, repl_d, rmv_q, rmv_d, drop_q, drop_d;
  oit_pkg::op_e op_q;
  oit_pkg::entry_t nw_q, head, push_ent;
  oit_pkg::entry_t cell_ent [oit_pkg::SLOTS];
  logic pop, push;
  logic in_xfer;

  assign in_xfer = in_valid_i && !in_stall_o;

  // latch the item
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      op_q                   <= oit_pkg::op_e'(opcode_i);
      nw_q.start_pos         <= start_pos_i;
      nw_q.end_pos           <= end_pos_i;
      nw_q.look.padding      <= padding_i;
      nw_q.look.inline_flag  <= inline_flag_i;
      nw_q.look.image_id     <= image_id_i;
      nw_q.look.image_width  <= image_width_i;
      nw_q.look.image_height <= image_height_i;
      nw_q.bg_color          <= bg_color_i;
      nw_q.source            <= source_i;
      nw_q.stamp             <= stamp_i;
      nw_q.is_new            <= 1'b1;
    end
  end

  assign head = cell_ent[0];

  // sequencer: head decisions and counters
  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    rem_d    = rem_q;
    placed_d = placed_q;
    repl_d   = repl_q;
    rmv_d    = rmv_q;
    drop_d   = drop_q;
    pop      = 1'b0;
    push     = 1'b0;
    push_ent = head;
    push_ent.is_new = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          state_d  = ST_WALK;
          rem_d    = cnt_q;
          placed_d = 1'b0;
          repl_d   = 1'b0;
          rmv_d    = 1'b0;
          drop_d   = 1'b0;
        end
      end
      ST_WALK: begin
        if (rem_q == '0) begin
          state_d = (op_q == oit_pkg::OP_INSERT && !placed_q) ? ST_TAIL : ST_CHECK;
        end else if (op_q == oit_pkg::OP_PURGE) begin
          pop = 1'b1;
          if (head.source == nw_q.source && head.stamp != nw_q.stamp) begin
            rmv_d = 1'b1;
          end else begin
            push = 1'b1;
          end
        end else if (placed_q) begin
          pop  = 1'b1;
          push = 1'b1;
        end else if (nw_q.end_pos <= head.start_pos) begin
          // new entry goes in front; head is handled next cycle
          push     = 1'b1;
          push_ent = nw_q;
          placed_d = 1'b1;
        end else if (nw_q.start_pos == head.start_pos && nw_q.end_pos == head.end_pos &&
                     nw_q.look == head.look && nw_q.bg_color == head.bg_color) begin
          pop      = 1'b1;
          push     = 1'b1;
          push_ent = nw_q;
          placed_d = 1'b1;
          repl_d   = 1'b1;
        end else if (nw_q.start_pos < head.end_pos) begin
          pop = 1'b1;  // intersecting entry evicted
        end else begin
          pop  = 1'b1;
          push = 1'b1;
        end
        if (pop) begin
          rem_d = rem_q - 1'b1;
        end
      end
      ST_TAIL: begin
        push     = 1'b1;
        push_ent = nw_q;
        state_d  = ST_CHECK;
      end
      ST_CHECK: begin
        if (cnt_q > oit_pkg::CW'(oit_pkg::DEPTH)) begin
          drop_d  = 1'b1;
          repl_d  = 1'b0;
          rem_d   = cnt_q;
          state_d = ST_FIX;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_FIX: begin
        // take the new entry back out, keep the rest in order
        if (rem_q == '0) begin
          state_d = ST_DONE;
        end else begin
          pop   = 1'b1;
          push  = !head.is_new;
          rem_d = rem_q - 1'b1;
        end
      end
      ST_DONE: begin
        if (!out_stall_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
    if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end else if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end
  end

  assign wpos = pop ? cnt_q - 1'b1 : cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      cnt_q    <= '0;
      rem_q    <= '0;
      placed_q <= 1'b0;
      repl_q   <= 1'b0;
      rmv_q    <= 1'b0;
      drop_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      rem_q    <= rem_d;
      placed_q <= placed_d;
      repl_q   <= repl_d;
      rmv_q    <= rmv_d;
      drop_q   <= drop_d;
    end
  end

  // slot chain
  for (genvar gi = 0; gi < oit_pkg::SLOTS; gi++) begin : g_cell
    oit_pkg::cell_ctl_t ctl;
    oit_pkg::entry_t    up;
    assign ctl.pop  = pop;
    assign ctl.load = push && (wpos == oit_pkg::CW'(gi));
    if (gi == oit_pkg::SLOTS - 1) begin : g_last
      assign up = '0;
    end else begin : g_mid
      assign up = cell_ent[gi+1];
    end
    oit_cell u_cell (
      .clk_i  (clk_i),
      .ctl_i  (ctl),
      .up_i   (up),
      .push_i (push_ent),
      .ent_o  (cell_ent[gi])
    );
  end

  assign in_stall_o    = (state_q != ST_IDLE);
  assign out_valid_o   = (state_q == ST_DONE);
  assign replaced_o    = repl_q;
  assign removed_any_o = rmv_q;
  assign dropped_o     = drop_q;
  assign entries_o     = 5'(cnt_q);

  `OIT_ASSERT_NOW(a_cnt_range, 1'b1, cnt_q <= oit_pkg::CW'(oit_pkg::SLOTS), "slot count overrun")
  `OIT_ASSERT_NOW(a_idle_fits, state_q == ST_IDLE, cnt_q <= oit_pkg::CW'(oit_pkg::DEPTH), "table over depth at rest")
  `OIT_ASSERT_NXT(a_start_walk, in_xfer, state_q == ST_WALK, "accepted item did not start a walk")
  `OIT_ASSERT_NOW(a_drop_clean, out_valid_o && dropped_o, !replaced_o, "drop reported with replace")
  `OIT_ASSERT_NOW(a_rem_le_cnt, state_q == ST_WALK, rem_q <= cnt_q, "walk count beyond queue fill")

endmodule

@@ test/oit_checker.sv @@
module oit_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic        opcode_i,
  input  logic [15:0] start_pos_i,
  input  logic [15:0] end_pos_i,
  input  logic [7:0]  padding_i,
  input  logic        inline_flag_i,
  input  logic [15:0] image_id_i,
  input  logic [11:0] image_width_i,
  input  logic [11:0] image_height_i,
  input  logic [31:0] bg_color_i,
  input  logic [1:0]  source_i,
  input  logic [31:0] stamp_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic        replaced_i,
  input  logic        removed_any_i,
  input  logic        dropped_i,
  input  logic [4:0]  entries_i,
  output int          fail_count_o,
  output int          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [15:0]    s;
    logic [15:0]    e;
    oit_pkg::look_t look;
    logic [31:0]    color;
    logic [1:0]     src;
    logic [31:0]    stamp;
  } slot_t;

  typedef struct packed {
    logic       replaced;
    logic       removed_any;
    logic       dropped;
    logic [4:0] entries;
  } outcome_t;

  slot_t    table_q[$];
  outcome_t outcome_q[$];
  int       fails;

  assign fail_count_o = fails;
  assign pending_o    = outcome_q.size();

  // predict one operation against the shadow table
  function automatic outcome_t apply_op();
    slot_t    nw;
    slot_t    nxt[$];
    outcome_t r;
    bit       placed;
    r = '0;
    placed = 0;
    if (oit_pkg::op_e'(opcode_i) == oit_pkg::OP_INSERT) begin
      nw.s = start_pos_i;
      nw.e = end_pos_i;
      nw.look = '{padding_i, inline_flag_i, image_id_i, image_width_i, image_height_i};
      nw.color = bg_color_i;
      nw.src = source_i;
      nw.stamp = stamp_i;
      foreach (table_q[i]) begin
        if (placed) nxt.push_back(table_q[i]);
        else if (nw.e <= table_q[i].s) begin
          nxt.push_back(nw);
          nxt.push_back(table_q[i]);
          placed = 1;
        end else if (nw.s == table_q[i].s && nw.e == table_q[i].e &&
                     nw.look == table_q[i].look && nw.color == table_q[i].color) begin
          nxt.push_back(nw);
          placed = 1;
          r.replaced = 1;
        end else if (nw.s < table_q[i].e) begin
          // overlap: evicted
        end else nxt.push_back(table_q[i]);
      end
      if (!placed) nxt.push_back(nw);
      if (nxt.size() > oit_pkg::DEPTH) begin
        r.dropped = 1;
        r.replaced = 0;
      end else table_q = nxt;
    end else begin
      foreach (table_q[i]) begin
        if (table_q[i].src == source_i && table_q[i].stamp != stamp_i) r.removed_any = 1;
        else nxt.push_back(table_q[i]);
      end
      table_q = nxt;
    end
    r.entries = 5'(table_q.size());
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    outcome_t want;
    if (!rst_ni) begin
      table_q.delete();
      outcome_q.delete();
      fails = 0;
    end else begin
      if (in_valid_i && !in_stall_i) outcome_q.push_back(apply_op());
      if (out_valid_i && !out_stall_i) begin
        if (outcome_q.size() == 0) begin
          $error("result transfer with nothing expected");
          fails++;
        end else begin
          want = outcome_q.pop_front();
          if (replaced_i !== want.replaced) begin
            $error("replaced: expected %0d got %0d", want.replaced, replaced_i);
            fails++;
          end
          if (removed_any_i !== want.removed_any) begin
            $error("removed_any: expected %0d got %0d", want.removed_any, removed_any_i);
            fails++;
          end
          if (dropped_i !== want.dropped) begin
            $error("dropped: expected %0d got %0d", want.dropped, dropped_i);
            fails++;
          end
          if (entries_i !== want.entries) begin
            $error("entries: expected %0d got %0d", want.entries, entries_i);
            fails++;
          end
        end
      end
    end
  end
endmodule

@@ test/tb_ordered_interval_table.sv @@
module tb_ordered_interval_table;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk_i, rst_ni;
  logic        in_valid_i, in_stall_o;
  logic        opcode_i;
  logic [15:0] start_pos_i, end_pos_i;
  logic [7:0]  padding_i;
  logic        inline_flag_i;
  logic [15:0] image_id_i;
  logic [11:0] image_width_i, image_height_i;
  logic [31:0] bg_color_i;
  logic [1:0]  source_i;
  logic [31:0] stamp_i;
  logic        out_valid_o, out_stall_i;
  logic        replaced_o, removed_any_o, dropped_o;
  logic [4:0]  entries_o;
  int          fail_count, pending;
  bit          calm;         // last part of the run: no idling
  int          hold_cycles;  // long receiver hold-off request

  ordered_interval_table dut (.*);

  oit_checker u_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .opcode_i,
    .start_pos_i, .end_pos_i, .padding_i, .inline_flag_i, .image_id_i,
    .image_width_i, .image_height_i, .bg_color_i, .source_i, .stamp_i,
    .out_valid_i(out_valid_o), .out_stall_i, .replaced_i(replaced_o),
    .removed_any_i(removed_any_o), .dropped_i(dropped_o), .entries_i(entries_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk_i = 0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #2000000;
    $display("Regression FAIL");
    $finish;
  end

  // receiver: random stall bursts plus one long hold-off
  initial begin
    int n;
    out_stall_i = 0;
    forever begin
      @(negedge clk_i);
      if (hold_cycles > 0) begin
        out_stall_i = 1;
        repeat (hold_cycles) @(negedge clk_i);
        hold_cycles = 0;
        out_stall_i = 0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 4);
        out_stall_i = 1;
        repeat (n - 1) @(negedge clk_i);
      end else out_stall_i = 0;
    end
  end

  // one transfer on the input channel, with a possible gap first
  task automatic send(logic op, logic [15:0] s, logic [15:0] e, logic [1:0] src,
                      logic [31:0] stp, bit rand_look);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
    in_valid_i <= 1;
    opcode_i <= op;
    start_pos_i <= s;
    end_pos_i <= e;
    source_i <= src;
    stamp_i <= stp;
    if (rand_look) begin
      // small look space so replacements happen
      padding_i <= $urandom_range(0, 1) ? 8'hff : 8'h00;
      inline_flag_i <= 1'($urandom_range(0, 1));
      image_id_i <= $urandom_range(0, 1) ? 16'hffff : 16'h0;
      image_width_i <= $urandom_range(0, 1) ? 12'hfff : 12'h0;
      image_height_i <= $urandom_range(0, 1) ? 12'hfff : 12'h0;
      bg_color_i <= $urandom_range(0, 1) ? 32'hffffffff : 32'h0;
    end else begin
      padding_i <= 8'($urandom);
      inline_flag_i <= 1'($urandom);
      image_id_i <= 16'($urandom);
      image_width_i <= 12'($urandom);
      image_height_i <= 12'($urandom);
      bg_color_i <= $urandom;
    end
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 0;
    while (pending != 0) @(negedge clk_i);
    repeat (80) @(negedge clk_i);
  endtask

  initial begin
    logic [15:0] a, w;
    int k;
    calm = 0;
    hold_cycles = 0;
    rst_ni = 0;
    in_valid_i = 0;
    opcode_i = oit_pkg::OP_INSERT;
    {start_pos_i, end_pos_i, padding_i, inline_flag_i, image_id_i} = '0;
    {image_width_i, image_height_i, bg_color_i, source_i, stamp_i} = '0;
    repeat (6) @(negedge clk_i);
    rst_ni = 1;
    @(negedge clk_i);

    // directed: purge on empty, extremes, overlap, reversed
    send(oit_pkg::OP_PURGE, 0, 0, 0, 0, 0);
    send(oit_pkg::OP_INSERT, 16'h0000, 16'hffff, 2'd3, 32'hffffffff, 1);
    send(oit_pkg::OP_INSERT, 16'h0000, 16'hffff, 2'd0, 32'h0, 0);
    send(oit_pkg::OP_INSERT, 16'h0010, 16'h0020, 2'd1, 32'd5, 0);
    send(oit_pkg::OP_INSERT, 16'h0020, 16'h0010, 2'd1, 32'd5, 0);
    send(oit_pkg::OP_INSERT, 16'h0030, 16'h0030, 2'd2, 32'd7, 0);
    padding_i <= 8'h5a;
    send(oit_pkg::OP_PURGE, 0, 0, 2'd1, 32'd5, 0);
    send(oit_pkg::OP_PURGE, 0, 0, 2'd2, 32'd9, 0);
    // fill past the table size: 18 disjoint entries on top of two held, last four dropped
    for (int i = 0; i < 18; i++)
      send(oit_pkg::OP_INSERT, 16'(100 * i + 1000), 16'(100 * i + 1050), 2'd2, 32'd1, 0);
    send(oit_pkg::OP_INSERT, 16'hfff0, 16'hffff, 2'd1, 32'd1, 0);
    send(oit_pkg::OP_PURGE, 0, 0, 2'd2, 32'd0, 0);
    drain();

    // sender keeps offering while the receiver holds off
    hold_cycles = 300;
    for (int i = 0; i < 10; i++)
      send(oit_pkg::OP_INSERT, 16'(i * 8), 16'(i * 8 + 4), 2'(i), 32'(i), 0);
    drain();

    // random: mostly inserts over a small region, some purges
    for (int i = 0; i < 400; i++) begin
      if (i == 330) calm = 1;
      k = $urandom_range(0, 9);
      if (k == 0) send(oit_pkg::OP_PURGE, 16'($urandom), 16'($urandom), 2'($urandom),
                       $urandom_range(0, 3), 0);
      else if (k == 1) send(oit_pkg::OP_INSERT, 16'($urandom), 16'($urandom),
                            2'($urandom), $urandom, 0);
      else begin
        a = 16'($urandom_range(0, 200));
        w = 16'($urandom_range(0, 12));
        send(oit_pkg::OP_INSERT, a, a + w, 2'($urandom), $urandom_range(0, 3), 1);
      end
    end

    in_valid_i <= 0;
    k = 0;
    while (pending != 0 && k < 20000) begin
      @(negedge clk_i);
      k++;
    end
    repeat (80) @(negedge clk_i);
    if (fail_count == 0 && pending == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end
endmodule

@@ filelist.f @@
+incdir+hw/rtl
hw/rtl/oit_pkg.sv
hw/rtl/oit_cell.sv
hw/rtl/ordered_interval_table.sv
test/oit_checker.sv
test/tb_ordered_interval_table.sv
